>>> rtl/csv_rfs_pkg.sv
// Package for the CSV record field splitter.
// Holds the character codes, the parser mode and result kind types, and the result struct.
// No dependencies; every other file of the block uses it.
package csv_rfs_pkg;

	localparam int MAX_COLUMNS_DEF = 64;

	localparam int DATA_W     = 8;
	localparam int KIND_W     = 2;
	localparam int COLUMN_W   = 6;
	localparam int ERRCOL_W   = 7;
	localparam int COUNT_W    = 7;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

	// Word index of the column count register.
	localparam logic REG_COLUMN_COUNT = 1'b0;

	localparam logic [DATA_W-1:0] CH_QUOTE   = 8'h22;
	localparam logic [DATA_W-1:0] CH_COMMA   = 8'h2C;
	localparam logic [DATA_W-1:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		MODE_START      = 3'd0,
		MODE_UNQUOTED   = 3'd1,
		MODE_QUOTED     = 3'd2,
		MODE_QUOTE_SEEN = 3'd3,
		MODE_SKIP       = 3'd4
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_OK    = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef struct packed {
		logic                valid;
		kind_t               kind;
		logic [DATA_W-1:0]   value;
		logic [COLUMN_W-1:0] column;
		logic [ERRCOL_W-1:0] error_column;
	} result_t;

endpackage

>>> rtl/csv_rfs_cfg.sv
// Configuration register file of the CSV record field splitter: the column count.
// APB-style write and read access, with pready tied high.
// Depends on csv_rfs_pkg.
module csv_rfs_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [csv_rfs_pkg::PADDR_W-1:0]      paddr,
	input  logic [csv_rfs_pkg::PDATA_W-1:0]      pwdata,
	output logic [csv_rfs_pkg::PDATA_W-1:0]      prdata,
	output logic                                 pready,
	output logic [csv_rfs_pkg::COUNT_W-1:0]      column_count
);

	logic                               hit;
	logic [csv_rfs_pkg::COUNT_W-1:0]    column_count_q;

	// Registers are word aligned, so the two low address bits are ignored.
	assign hit = (paddr[csv_rfs_pkg::PADDR_W-1] == csv_rfs_pkg::REG_COLUMN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= csv_rfs_pkg::COUNT_RESET;
		end else if (psel && penable && pwrite && hit) begin
			column_count_q <= pwdata[csv_rfs_pkg::COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(csv_rfs_pkg::PDATA_W - csv_rfs_pkg::COUNT_W){1'b0}}, column_count_q};
		end
	end

	assign pready       = 1'b1;
	assign column_count = column_count_q;

endmodule

>>> rtl/csv_rfs_parser.sv
// Input register and parse state machine of the CSV record field splitter.
// Produces at most one result per byte for the output register.
// Depends on csv_rfs_pkg.
module csv_rfs_parser #(
	parameter int MAX_COLUMNS = csv_rfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [csv_rfs_pkg::DATA_W-1:0]       data_byte,
	output logic                                 in_stall,
	input  logic [csv_rfs_pkg::COUNT_W-1:0]      column_count,
	input  logic                                 out_free,
	output csv_rfs_pkg::result_t                 res
);

	localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CMP_W = (IDX_W + 1 > csv_rfs_pkg::COUNT_W) ? IDX_W + 1
		: csv_rfs_pkg::COUNT_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_COLUMNS);

	logic                             valid_s1;
	logic [csv_rfs_pkg::DATA_W-1:0]   byte_s1;
	csv_rfs_pkg::mode_t               mode_q;
	csv_rfs_pkg::mode_t               mode_d;
	logic [IDX_W-1:0]                 idx_q;
	logic [IDX_W-1:0]                 idx_d;

	logic                             consume;
	logic                             accept;
	logic                             is_sep;
	logic                             is_newline;
	logic [CMP_W-1:0]                 count_ext;
	logic [CMP_W-1:0]                 eff_count;
	logic [CMP_W-1:0]                 ended;
	logic [CMP_W-1:0]                 next;
	logic                             has_res;
	csv_rfs_pkg::kind_t               kind_d;
	logic [csv_rfs_pkg::DATA_W-1:0]   value_d;
	logic [CMP_W-1:0]                 errcol_d;

	// A column count of zero acts as one, and one above the limit acts as the limit.
	always_comb begin
		count_ext = CMP_W'(column_count);
		eff_count = count_ext;
		if (count_ext == '0) begin
			eff_count = CMP_W'(1);
		end else if (count_ext > MAX_CMP) begin
			eff_count = MAX_CMP;
		end
	end

	assign is_newline = (byte_s1 == csv_rfs_pkg::CH_NEWLINE);
	assign is_sep     = is_newline || (byte_s1 == csv_rfs_pkg::CH_COMMA);
	assign ended      = CMP_W'(idx_q);
	assign next       = ended + CMP_W'(1);

	always_comb begin
		mode_d   = mode_q;
		idx_d    = idx_q;
		has_res  = 1'b0;
		kind_d   = csv_rfs_pkg::KIND_BYTE;
		value_d  = '0;
		errcol_d = '0;
		case (mode_q)
			csv_rfs_pkg::MODE_START,
			csv_rfs_pkg::MODE_UNQUOTED,
			csv_rfs_pkg::MODE_QUOTED,
			csv_rfs_pkg::MODE_QUOTE_SEEN: begin
				if ((mode_q == csv_rfs_pkg::MODE_START) && (byte_s1 == csv_rfs_pkg::CH_QUOTE)) begin
					mode_d = csv_rfs_pkg::MODE_QUOTED;
				end else if ((mode_q == csv_rfs_pkg::MODE_QUOTED)
						&& (byte_s1 == csv_rfs_pkg::CH_QUOTE)) begin
					mode_d = csv_rfs_pkg::MODE_QUOTE_SEEN;
				end else if ((mode_q == csv_rfs_pkg::MODE_QUOTE_SEEN)
						&& (byte_s1 == csv_rfs_pkg::CH_QUOTE)) begin
					// A doubled quote inside a quoted field is one literal quote.
					mode_d  = csv_rfs_pkg::MODE_QUOTED;
					has_res = 1'b1;
					value_d = byte_s1;
				end else if (is_sep && (mode_q != csv_rfs_pkg::MODE_QUOTED)) begin
					// The separator ends the current field.
					has_res = 1'b1;
					mode_d  = csv_rfs_pkg::MODE_START;
					if (next >= eff_count) begin
						kind_d = csv_rfs_pkg::KIND_OK;
						idx_d  = '0;
						if (!is_newline) begin
							mode_d = csv_rfs_pkg::MODE_SKIP;
						end
					end else if (is_newline) begin
						kind_d   = csv_rfs_pkg::KIND_ERROR;
						idx_d    = '0;
						errcol_d = next + CMP_W'(1);
					end else begin
						kind_d = csv_rfs_pkg::KIND_END;
						idx_d  = next[IDX_W-1:0];
					end
				end else if (mode_q == csv_rfs_pkg::MODE_QUOTE_SEEN) begin
					// Stray byte after a closing quote.
					has_res  = 1'b1;
					kind_d   = csv_rfs_pkg::KIND_ERROR;
					errcol_d = next;
					idx_d    = '0;
					mode_d   = csv_rfs_pkg::MODE_SKIP;
				end else begin
					has_res = 1'b1;
					value_d = byte_s1;
					if (mode_q == csv_rfs_pkg::MODE_START) begin
						mode_d = csv_rfs_pkg::MODE_UNQUOTED;
					end
				end
			end
			default: begin
				if (is_newline) begin
					idx_d  = '0;
					mode_d = csv_rfs_pkg::MODE_START;
				end
			end
		endcase
	end

	always_comb begin
		res.valid        = valid_s1 && has_res;
		res.kind         = kind_d;
		res.value        = value_d;
		res.column       = ended[csv_rfs_pkg::COLUMN_W-1:0];
		res.error_column = errcol_d[csv_rfs_pkg::ERRCOL_W-1:0];
	end

	assign consume  = valid_s1 && (!has_res || out_free);
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= csv_rfs_pkg::MODE_START;
			idx_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (consume) begin
				mode_q <= mode_d;
				idx_q  <= idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

>>> rtl/csv_rfs_out.sv
// Result register of the CSV record field splitter.
// Holds one result until the downstream side takes it.
// Depends on csv_rfs_pkg.
module csv_rfs_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  csv_rfs_pkg::result_t                 res,
	output logic                                 out_free,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [csv_rfs_pkg::KIND_W-1:0]       kind,
	output logic [csv_rfs_pkg::DATA_W-1:0]       value,
	output logic [csv_rfs_pkg::COLUMN_W-1:0]     column,
	output logic [csv_rfs_pkg::ERRCOL_W-1:0]     error_column
);

	logic                                 valid_q;
	csv_rfs_pkg::kind_t                   kind_q;
	logic [csv_rfs_pkg::DATA_W-1:0]       value_q;
	logic [csv_rfs_pkg::COLUMN_W-1:0]     column_q;
	logic [csv_rfs_pkg::ERRCOL_W-1:0]     error_column_q;
	logic                                 load;

	// The register can take a new result when empty or when its content leaves now.
	assign out_free = !valid_q || !out_stall;
	assign load     = res.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q         <= res.kind;
			value_q        <= res.value;
			column_q       <= res.column;
			error_column_q <= res.error_column;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = kind_q;
	assign value        = value_q;
	assign column       = column_q;
	assign error_column = error_column_q;

endmodule

>>> rtl/csv_record_field_splitter.sv
// Top level of the CSV record field splitter.
// Instantiates csv_rfs_cfg, csv_rfs_parser and csv_rfs_out; depends on csv_rfs_pkg.
//
//   Channel   Handshake            Payload
//   -------   ------------------   -----------------------------------------
//   input     in_valid / in_stall  data_byte
//   output    out_valid/ out_stall kind, value, column, error_column
//   config    APB (psel..pready)   column_count at byte address 0
//
// The block takes one byte in every cycle while in_stall is low. A byte is
// captured in the input register and parsed against the mode and field
// index, and its result, if it has one, is then loaded into the result
// register. Reset clears the mode to field start, the field index to zero
// and the column count to one. A stall on the output holds the result
// register; the input stalls only when the byte in the input register has
// a result and the result register cannot take it.
module csv_record_field_splitter #(
	parameter int MAX_COLUMNS = csv_rfs_pkg::MAX_COLUMNS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [csv_rfs_pkg::DATA_W-1:0]       data_byte,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [csv_rfs_pkg::KIND_W-1:0]       kind,
	output logic [csv_rfs_pkg::DATA_W-1:0]       value,
	output logic [csv_rfs_pkg::COLUMN_W-1:0]     column,
	output logic [csv_rfs_pkg::ERRCOL_W-1:0]     error_column,

	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [csv_rfs_pkg::PADDR_W-1:0]      paddr,
	input  logic [csv_rfs_pkg::PDATA_W-1:0]      pwdata,
	output logic [csv_rfs_pkg::PDATA_W-1:0]      prdata,
	output logic                                 pready
);

	logic [csv_rfs_pkg::COUNT_W-1:0]  column_count;
	logic                             out_free;
	csv_rfs_pkg::result_t             res;

	// Write the column count register only while the block is idle (unchecked here).
	csv_rfs_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.column_count (column_count)
	);

	// Input register, mode and field index, and the per-byte decision.
	csv_rfs_parser #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.data_byte    (data_byte),
		.in_stall     (in_stall),
		.column_count (column_count),
		.out_free     (out_free),
		.res          (res)
	);

	// Result register, which holds the parser's result while the downstream side stalls.
	csv_rfs_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.value        (value),
		.column       (column),
		.error_column (error_column)
	);

endmodule
